>>> src/positional_insert_delete_list_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ordered insert/delete list
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_DELETE_LIST_DEFINES_SVH
`define POSITIONAL_INSERT_DELETE_LIST_DEFINES_SVH

// same-cycle implication
`define PLID_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plid check failed: same-cycle");

// next-cycle implication
`define PLID_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plid check failed: next-cycle");

`endif

>>> src/plid_pkg.sv
// ---------------------------------------------------------------------------
// plid_pkg
// Command codes, status codes and cell operation type for the list.
// ---------------------------------------------------------------------------
package plid_pkg;

    localparam int unsigned CMD_W   = 3;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE_END = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REM_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INS_POS    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REM_POS    = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_FROM_LEFT,
        OP_FROM_RIGHT
    } cell_op_t;

endpackage

>>> src/positional_insert_delete_list.sv
// ---------------------------------------------------------------------------
// positional_insert_delete_list
// Ordered list of signed 32-bit values kept in a row of shifting cells,
// with append, insert and remove at the ends or at a 1-based position.
// ---------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)              | tlast | tuser
//  s_axis  | in  | cmd[3], value[32], position[POS_W], pad | -     | -
//  m_axis  | out | status[2], removed_value[32], count, pad| -     | -
//
//  One beat is taken per clock when s_tready is high; its result is registered
//  and shown the next cycle. All cells shift, load or hold together then.
//  s_tready stays high while the output register is empty or being read.
//  Reset clears the count and output valid; cell contents are not reset.
// ---------------------------------------------------------------------------
`include "positional_insert_delete_list_defines.svh"

module positional_insert_delete_list #(
    parameter  int unsigned LIST_DEPTH = 16,
    localparam int unsigned POS_W      = $clog2(LIST_DEPTH + 2),
    localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1),
    localparam int unsigned IN_W       = ((3 + 32 + POS_W + 7) / 8) * 8,
    localparam int unsigned OUT_W      = ((2 + 32 + CNT_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // cmd, value, position, zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, removed_value, count, zero pad
);
    import plid_pkg::*;

    localparam int unsigned POS_LSB = CMD_W + VALUE_W;
    localparam int unsigned OUT_USED = STAT_W + VALUE_W + CNT_W;

    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    logic             accept;
    logic             is_ins;
    logic             is_rem;
    logic             full;
    logic             empty;
    logic [POS_W-1:0] count_ext;
    logic [POS_W-1:0] idx;
    logic             do_ins;
    logic             do_rem;
    logic [STAT_W-1:0] status_next;
    logic signed [VALUE_W-1:0] removed_next;

    logic [VALUE_W-1:0] cell_data [LIST_DEPTH];
    cell_op_t           cell_op   [LIST_DEPTH];

    assign cmd      = s_tdata[CMD_W-1:0];
    assign value    = s_tdata[CMD_W +: VALUE_W];
    assign position = s_tdata[POS_LSB +: POS_W];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign is_ins = (cmd == CMD_APPEND) || (cmd == CMD_INS_FRONT) || (cmd == CMD_INS_POS);
    assign is_rem = (cmd == CMD_REMOVE_END) || (cmd == CMD_REM_FRONT) || (cmd == CMD_REM_POS);
    assign full      = (count_reg == CNT_W'(LIST_DEPTH));
    assign empty     = (count_reg == '0);
    assign count_ext = POS_W'(count_reg);

    always_comb
    begin
        status_next = ST_OK;
        do_ins      = 1'b0;
        do_rem      = 1'b0;
        idx         = '0;
        case (cmd)
            CMD_APPEND:     idx = count_ext;
            CMD_REMOVE_END: idx = count_ext - POS_W'(1);
            CMD_INS_POS,
            CMD_REM_POS:    idx = position - POS_W'(1);
            default:        idx = '0;
        endcase
        if (is_ins)
        begin
            if (full)
                status_next = ST_FULL;
            else if ((cmd == CMD_INS_POS) &&
                     ((position == '0) || (position > count_ext + POS_W'(1))))
                status_next = ST_BADPOS;
            else
                do_ins = 1'b1;
        end
        else if (is_rem)
        begin
            if (empty)
                status_next = ST_EMPTY;
            else if ((cmd == CMD_REM_POS) &&
                     ((position == '0) || (position > count_ext)))
                status_next = ST_BADPOS;
            else
                do_rem = 1'b1;
        end
    end

    always_comb
    begin
        removed_next = '0;
        for (int k = 0; k < LIST_DEPTH; k++)
        begin
            if (do_rem && (POS_W'(k) == idx))
                removed_next = removed_next | cell_data[k];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept && do_ins)
            count_next = count_reg + CNT_W'(1);
        else if (accept && do_rem)
            count_next = count_reg - CNT_W'(1);
    end

    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        localparam logic [POS_W-1:0] CELL_IDX = POS_W'(i);
        logic [VALUE_W-1:0] left_data;
        logic [VALUE_W-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = value;
        end
        else
        begin : g_inner_left
            assign left_data = cell_data[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner_right
            assign right_data = cell_data[i+1];
        end

        always_comb
        begin
            cell_op[i] = OP_HOLD;
            if (accept && do_ins)
            begin
                if (CELL_IDX == idx)
                    cell_op[i] = OP_LOAD;
                else if (CELL_IDX > idx)
                    cell_op[i] = OP_FROM_LEFT;
            end
            else if (accept && do_rem && (CELL_IDX >= idx))
                cell_op[i] = OP_FROM_RIGHT;
        end

        plid_cell u_cell (
            .clk        (clk),
            .op         (cell_op[i]),
            .load_data  (value),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= {{(OUT_W - OUT_USED){1'b0}}, count_next, removed_next,
                             status_next};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `PLID_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(LIST_DEPTH))
    `PLID_ASSERT_NEXT(a_result_shown, accept, m_tvalid)
    `PLID_ASSERT_NEXT(a_error_holds_count, accept && (status_next != ST_OK),
                      count_reg == $past(count_reg))
    `PLID_ASSERT_NEXT(a_count_step, accept && (do_ins || do_rem),
                      (count_reg == $past(count_reg) + CNT_W'(1)) ||
                      (count_reg == $past(count_reg) - CNT_W'(1)))

endmodule

>>> src/plid_cell.sv
// ---------------------------------------------------------------------------
// plid_cell
// One list slot: holds, loads the new value, or takes a neighbour's value.
// ---------------------------------------------------------------------------
module plid_cell (
    input  logic                           clk,
    input  plid_pkg::cell_op_t             op,
    input  logic [plid_pkg::VALUE_W-1:0]   load_data,
    input  logic [plid_pkg::VALUE_W-1:0]   left_data,
    input  logic [plid_pkg::VALUE_W-1:0]   right_data,
    output logic [plid_pkg::VALUE_W-1:0]   data
);
    import plid_pkg::*;

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;

    always_comb
    begin
        case (op)
            OP_LOAD:       data_next = load_data;
            OP_FROM_LEFT:  data_next = left_data;
            OP_FROM_RIGHT: data_next = right_data;
            default:       data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
